[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the remap checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rdr_pkg.sv]
// ---------------------------------------------------------------------------
// rdr_pkg
// Types, register codes and width helpers for the radial distortion remap.
// ---------------------------------------------------------------------------
package rdr_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int CENTER_W   = 12;
    localparam int SIZE_W     = 13;
    localparam int COEF_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // k1 is scaled by 2^-48, k2 by 2^-64: k1 lines up with k2*s after << 16
    localparam int K1_SHIFT  = 16;
    localparam int FRAC_BITS = 64;

    localparam logic [CENTER_W-1:0]      CENTER_RESET = '0;
    localparam logic signed [COEF_W-1:0] K1_RESET     = 32'sd281475;
    localparam logic signed [COEF_W-1:0] K2_RESET     = 32'sd14757395;
    localparam logic [SIZE_W-1:0]        SIZE_RESET   = 13'd4096;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_K1_COEFF     = 3'd2,
        REG_K2_COEFF     = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } t_cfg_reg;

    // per-axis control that rides along with the wide product
    typedef struct packed {
        logic valid;
        logic neg;     // offset is negative
    } t_lane_ctl;

    // |d| * s : C bits times 2C+1 bits
    function automatic int amp_w(input int c);
        return 3 * c + 1;
    endfunction

    // signed k1*2^16 + k2*s, with room for the small-coordinate case
    function automatic int gain_w(input int c);
        return (2 * c + 34 > 49) ? 2 * c + 34 : 49;
    endfunction

    // two coordinates packed, padded to whole bytes
    function automatic int tdata_w(input int c);
        return ((2 * c + 7) / 8) * 8;
    endfunction

endpackage

[rtl/core/radial_distortion_remap_unit.sv]
// ---------------------------------------------------------------------------
// radial_distortion_remap_unit - two-coefficient radial lens remap
// Throughput: one beat per clock while the output is not stalled; a stalled
//   result parks in the output skid register while the 9-stage pipeline holds.
// Reset: sync active-low; clears valids and skid, loads config defaults.
// ---------------------------------------------------------------------------
module radial_distortion_remap_unit #(
    parameter int COORD_BITS = rdr_pkg::COORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // destination pixel stream
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: [C-1:0] pixel_x, [2C-1:C] pixel_y, zero pad above
    input  logic [rdr_pkg::tdata_w(COORD_BITS)-1:0]  i_s_axis_tdata,
    // source coordinate stream
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // tdata: [C-1:0] source_x, [2C-1:C] source_y, zero pad above
    output logic [rdr_pkg::tdata_w(COORD_BITS)-1:0]  o_m_axis_tdata,
    // tuser: [0] in_range
    output logic [0:0]                               o_m_axis_tuser,
    // register write port
    input  logic                                     i_cfg_we,
    input  logic [rdr_pkg::CFG_ADDR_W-1:0]           i_cfg_addr,
    input  logic [rdr_pkg::CFG_DATA_W-1:0]           i_cfg_wdata
);

    localparam int C   = COORD_BITS;
    localparam int AW  = rdr_pkg::amp_w(C);
    localparam int GW  = rdr_pkg::gain_w(C);
    localparam int TDW = rdr_pkg::tdata_w(C);

    // Pipeline map
    //   1     dx, dy against the center; sign and magnitude
    //   2     s = dx^2 + dy^2
    //   3     |dx|*s, |dy|*s, k2*s
    //   4     G = k1*2^16 + k2*s  (so N = s*G in units of 2^-64)
    //   5     |G|; offset sign per axis = sign(d) ^ sign(G)
    //   6-8   per axis |d|*s*|G| as four partial products, two adds,
    //         then >> 64 and clamp the magnitude to 2^C
    //   9     source = pixel - offset, bounds check, output register
    // All stages share one advance enable driven by the skid register.

    // ---- configuration registers ------------------------------------------
    logic [rdr_pkg::CENTER_W-1:0]      r_center_x, r_center_y;
    logic signed [rdr_pkg::COEF_W-1:0] r_k1, r_k2;
    logic [rdr_pkg::SIZE_W-1:0]        r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= rdr_pkg::CENTER_RESET;
            r_center_y <= rdr_pkg::CENTER_RESET;
            r_k1       <= rdr_pkg::K1_RESET;
            r_k2       <= rdr_pkg::K2_RESET;
            r_width    <= rdr_pkg::SIZE_RESET;
            r_height   <= rdr_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (rdr_pkg::t_cfg_reg'(i_cfg_addr))
                rdr_pkg::REG_CENTER_X:     r_center_x <= i_cfg_wdata[rdr_pkg::CENTER_W-1:0];
                rdr_pkg::REG_CENTER_Y:     r_center_y <= i_cfg_wdata[rdr_pkg::CENTER_W-1:0];
                rdr_pkg::REG_K1_COEFF:     r_k1       <= i_cfg_wdata[rdr_pkg::COEF_W-1:0];
                rdr_pkg::REG_K2_COEFF:     r_k2       <= i_cfg_wdata[rdr_pkg::COEF_W-1:0];
                rdr_pkg::REG_IMAGE_WIDTH:  r_width    <= i_cfg_wdata[rdr_pkg::SIZE_W-1:0];
                rdr_pkg::REG_IMAGE_HEIGHT: r_height   <= i_cfg_wdata[rdr_pkg::SIZE_W-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // center taken modulo the coordinate span
    logic [C-1:0] w_center_x, w_center_y;
    assign w_center_x = C'(r_center_x);
    assign w_center_y = C'(r_center_y);

    // ---- stream control -----------------------------------------------------
    logic w_adv;
    assign o_s_axis_tready = w_adv;

    // ---- stages 1-5 ---------------------------------------------------------
    rdr_pkg::t_lane_ctl w_ctl5_x, w_ctl5_y;
    logic [AW-1:0]      w_amp_x, w_amp_y;
    logic [GW-1:0]      w_gain;
    logic [C-1:0]       w_px5, w_py5;

    rdr_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (i_s_axis_tvalid),
        .i_pixel_x  (i_s_axis_tdata[C-1:0]),
        .i_pixel_y  (i_s_axis_tdata[2*C-1:C]),
        .i_center_x (w_center_x),
        .i_center_y (w_center_y),
        .i_k1       (r_k1),
        .i_k2       (r_k2),
        .o_ctl_x    (w_ctl5_x),
        .o_ctl_y    (w_ctl5_y),
        .o_amp_x    (w_amp_x),
        .o_amp_y    (w_amp_y),
        .o_gain     (w_gain),
        .o_pixel_x  (w_px5),
        .o_pixel_y  (w_py5)
    );

    // ---- stages 6-8, one lane per axis -------------------------------------
    rdr_pkg::t_lane_ctl w_ctl8_x, w_ctl8_y;
    logic [C:0]         w_mag_x, w_mag_y;
    logic [C-1:0]       w_px8, w_py8;

    rdr_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_ctl   (w_ctl5_x),
        .i_amp   (w_amp_x),
        .i_gain  (w_gain),
        .i_coord (w_px5),
        .o_ctl   (w_ctl8_x),
        .o_mag   (w_mag_x),
        .o_coord (w_px8)
    );

    rdr_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_ctl   (w_ctl5_y),
        .i_amp   (w_amp_y),
        .i_gain  (w_gain),
        .i_coord (w_py5),
        .o_ctl   (w_ctl8_y),
        .o_mag   (w_mag_y),
        .o_coord (w_py8)
    );

    // ---- stage 9 and output skid -------------------------------------------
    logic [C-1:0] w_src_x, w_src_y;
    logic         w_in_range;

    rdr_out #(
        .COORD_BITS (COORD_BITS)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl_x        (w_ctl8_x),
        .i_ctl_y        (w_ctl8_y),
        .i_mag_x        (w_mag_x),
        .i_mag_y        (w_mag_y),
        .i_pixel_x      (w_px8),
        .i_pixel_y      (w_py8),
        .i_image_width  (r_width),
        .i_image_height (r_height),
        .i_m_tready     (i_m_axis_tready),
        .o_adv          (w_adv),
        .o_valid        (o_m_axis_tvalid),
        .o_source_x     (w_src_x),
        .o_source_y     (w_src_y),
        .o_in_range     (w_in_range)
    );

    assign o_m_axis_tdata = TDW'({w_src_y, w_src_x});
    assign o_m_axis_tuser = w_in_range;

endmodule

[rtl/core/rdr_geom.sv]
// ---------------------------------------------------------------------------
// rdr_geom
// Stages 1-5: center deltas, squared radius, gain and its magnitude.
// ---------------------------------------------------------------------------
module rdr_geom #(
    parameter int COORD_BITS = rdr_pkg::COORD_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  logic [COORD_BITS-1:0]                        i_pixel_x,
    input  logic [COORD_BITS-1:0]                        i_pixel_y,
    input  logic [COORD_BITS-1:0]                        i_center_x,
    input  logic [COORD_BITS-1:0]                        i_center_y,
    input  logic signed [rdr_pkg::COEF_W-1:0]            i_k1,
    input  logic signed [rdr_pkg::COEF_W-1:0]            i_k2,
    output rdr_pkg::t_lane_ctl                           o_ctl_x,
    output rdr_pkg::t_lane_ctl                           o_ctl_y,
    output logic [rdr_pkg::amp_w(COORD_BITS)-1:0]        o_amp_x,
    output logic [rdr_pkg::amp_w(COORD_BITS)-1:0]        o_amp_y,
    output logic [rdr_pkg::gain_w(COORD_BITS)-1:0]       o_gain,
    output logic [COORD_BITS-1:0]                        o_pixel_x,
    output logic [COORD_BITS-1:0]                        o_pixel_y
);

    localparam int C  = COORD_BITS;
    localparam int SW = 2 * C + 1;
    localparam int AW = rdr_pkg::amp_w(C);
    localparam int GW = rdr_pkg::gain_w(C);

    // stage 1: signed deltas, split into sign and magnitude
    logic [C:0]   w_dx, w_dy, w_dx_abs, w_dy_abs;
    logic         r1_v, r1_nx, r1_ny;
    logic [C-1:0] r1_x, r1_y, r1_adx, r1_ady;

    assign w_dx     = {1'b0, i_pixel_x} - {1'b0, i_center_x};
    assign w_dy     = {1'b0, i_pixel_y} - {1'b0, i_center_y};
    assign w_dx_abs = w_dx[C] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_abs = w_dy[C] ? (~w_dy + 1'b1) : w_dy;

    // stage 2: squared radius
    logic [SW-1:0] w_s;
    logic          r2_v, r2_nx, r2_ny;
    logic [C-1:0]  r2_x, r2_y, r2_adx, r2_ady;
    logic [SW-1:0] r2_s;

    assign w_s = SW'(r1_adx) * SW'(r1_adx) + SW'(r1_ady) * SW'(r1_ady);

    // stage 3: |d|*s per axis and k2*s
    logic                 r3_v, r3_nx, r3_ny;
    logic [C-1:0]         r3_x, r3_y;
    logic [AW-1:0]        r3_ax, r3_ay;
    logic signed [GW-1:0] r3_kp;

    // stage 4: gain
    logic                 r4_v, r4_nx, r4_ny;
    logic [C-1:0]         r4_x, r4_y;
    logic [AW-1:0]        r4_ax, r4_ay;
    logic signed [GW-1:0] r4_g;

    // stage 5: gain magnitude, offset signs resolved
    logic [GW-1:0] w_gmag;
    logic          w_gneg;
    logic          r5_v, r5_nx, r5_ny;
    logic [C-1:0]  r5_x, r5_y;
    logic [AW-1:0] r5_ax, r5_ay;
    logic [GW-1:0] r5_gmag;

    assign w_gneg = r4_g[GW-1];
    assign w_gmag = w_gneg ? (~r4_g + 1'b1) : r4_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x    <= i_pixel_x;
            r1_y    <= i_pixel_y;
            r1_adx  <= w_dx_abs[C-1:0];
            r1_ady  <= w_dy_abs[C-1:0];
            r1_nx   <= w_dx[C];
            r1_ny   <= w_dy[C];

            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_adx  <= r1_adx;
            r2_ady  <= r1_ady;
            r2_nx   <= r1_nx;
            r2_ny   <= r1_ny;
            r2_s    <= w_s;

            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_nx   <= r2_nx;
            r3_ny   <= r2_ny;
            r3_ax   <= AW'(r2_adx) * AW'(r2_s);
            r3_ay   <= AW'(r2_ady) * AW'(r2_s);
            r3_kp   <= GW'(i_k2) * GW'($signed({1'b0, r2_s}));

            r4_x    <= r3_x;
            r4_y    <= r3_y;
            r4_nx   <= r3_nx;
            r4_ny   <= r3_ny;
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_g    <= r3_kp + (GW'(i_k1) <<< rdr_pkg::K1_SHIFT);

            r5_x    <= r4_x;
            r5_y    <= r4_y;
            r5_nx   <= r4_nx ^ w_gneg;
            r5_ny   <= r4_ny ^ w_gneg;
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
            r5_gmag <= w_gmag;
        end
    end

    assign o_ctl_x   = '{valid: r5_v, neg: r5_nx};
    assign o_ctl_y   = '{valid: r5_v, neg: r5_ny};
    assign o_amp_x   = r5_ax;
    assign o_amp_y   = r5_ay;
    assign o_gain    = r5_gmag;
    assign o_pixel_x = r5_x;
    assign o_pixel_y = r5_y;

endmodule

[rtl/core/rdr_lane.sv]
// ---------------------------------------------------------------------------
// rdr_lane
// Stages 6-8 of one axis: |d|*s*|G| as four partial products, summed,
// scaled by 2^-64 and clamped to the coordinate span.
// ---------------------------------------------------------------------------
module rdr_lane #(
    parameter int COORD_BITS = rdr_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  rdr_pkg::t_lane_ctl                     i_ctl,
    input  logic [rdr_pkg::amp_w(COORD_BITS)-1:0]  i_amp,
    input  logic [rdr_pkg::gain_w(COORD_BITS)-1:0] i_gain,
    input  logic [COORD_BITS-1:0]                  i_coord,
    output rdr_pkg::t_lane_ctl                     o_ctl,
    output logic [COORD_BITS:0]                    o_mag,
    output logic [COORD_BITS-1:0]                  o_coord
);

    localparam int C    = COORD_BITS;
    localparam int AW   = rdr_pkg::amp_w(C);
    localparam int GW   = rdr_pkg::gain_w(C);
    localparam int AL   = (AW + 1) / 2;
    localparam int AH   = AW - AL;
    localparam int GL   = (GW + 1) / 2;
    localparam int GH   = GW - GL;
    localparam int LLW  = AL + GL;
    localparam int LHW  = AL + GH;
    localparam int HLW  = AH + GL;
    localparam int HHW  = AH + GH;
    localparam int PW   = AW + GW;
    localparam int FRAC = rdr_pkg::FRAC_BITS;
    localparam int PE   = (PW > FRAC + C + 1) ? PW : FRAC + C + 1;
    localparam int QRW  = PE - FRAC;
    localparam logic [QRW-1:0] QSPAN = QRW'(1) << C;

    rdr_pkg::t_lane_ctl     r6_ctl, r7_ctl, r8_ctl;
    logic [C-1:0]           r6_coord, r7_coord, r8_coord;
    logic [LLW-1:0]         r6_ll;
    logic [LHW-1:0]         r6_lh;
    logic [HLW-1:0]         r6_hl;
    logic [HHW-1:0]         r6_hh;
    logic [PW-1:0]          r7_t0, r7_t1;
    logic [C:0]             r8_mag;

    logic [PW-1:0]  w_p;
    logic [PE-1:0]  w_pe;
    logic [QRW-1:0] w_q;
    logic [C:0]     w_mag;

    assign w_p   = r7_t0 + r7_t1;
    assign w_pe  = PE'(w_p);
    assign w_q   = w_pe[PE-1:FRAC];
    assign w_mag = (w_q > QSPAN) ? QSPAN[C:0] : w_q[C:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctl.valid <= 1'b0;
            r7_ctl.valid <= 1'b0;
            r8_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r6_ctl.valid <= i_ctl.valid;
            r7_ctl.valid <= r6_ctl.valid;
            r8_ctl.valid <= r7_ctl.valid;
        end

        if (i_en) begin
            r6_ctl.neg <= i_ctl.neg;
            r6_coord   <= i_coord;
            r6_ll      <= LLW'(i_amp[AL-1:0])  * LLW'(i_gain[GL-1:0]);
            r6_lh      <= LHW'(i_amp[AL-1:0])  * LHW'(i_gain[GW-1:GL]);
            r6_hl      <= HLW'(i_amp[AW-1:AL]) * HLW'(i_gain[GL-1:0]);
            r6_hh      <= HHW'(i_amp[AW-1:AL]) * HHW'(i_gain[GW-1:GL]);

            r7_ctl.neg <= r6_ctl.neg;
            r7_coord   <= r6_coord;
            r7_t0      <= PW'(r6_ll) + (PW'(r6_hh) << (AL + GL));
            r7_t1      <= (PW'(r6_lh) << GL) + (PW'(r6_hl) << AL);

            r8_ctl.neg <= r7_ctl.neg;
            r8_coord   <= r7_coord;
            r8_mag     <= w_mag;
        end
    end

    assign o_ctl   = r8_ctl;
    assign o_mag   = r8_mag;
    assign o_coord = r8_coord;

endmodule

[rtl/core/rdr_out.sv]
// ---------------------------------------------------------------------------
// rdr_out
// Stage 9: signed offsets, source coordinates, bounds check; output register
// plus skid register toward the downstream port.
// ---------------------------------------------------------------------------
module rdr_out #(
    parameter int COORD_BITS = rdr_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rdr_pkg::t_lane_ctl          i_ctl_x,
    input  rdr_pkg::t_lane_ctl          i_ctl_y,
    input  logic [COORD_BITS:0]         i_mag_x,
    input  logic [COORD_BITS:0]         i_mag_y,
    input  logic [COORD_BITS-1:0]       i_pixel_x,
    input  logic [COORD_BITS-1:0]       i_pixel_y,
    input  logic [rdr_pkg::SIZE_W-1:0]  i_image_width,
    input  logic [rdr_pkg::SIZE_W-1:0]  i_image_height,
    input  logic                        i_m_tready,
    output logic                        o_adv,
    output logic                        o_valid,
    output logic [COORD_BITS-1:0]       o_source_x,
    output logic [COORD_BITS-1:0]       o_source_y,
    output logic                        o_in_range
);

    localparam int C    = COORD_BITS;
    localparam int CMPW = (C > rdr_pkg::SIZE_W) ? C : rdr_pkg::SIZE_W;

    logic [C+1:0] w_off_x, w_off_y, w_sx, w_sy;
    logic         w_ok_x, w_ok_y, w_ok, w_valid;

    assign w_valid = i_ctl_x.valid & i_ctl_y.valid;

    assign w_off_x = i_ctl_x.neg ? (~{1'b0, i_mag_x} + 1'b1) : {1'b0, i_mag_x};
    assign w_off_y = i_ctl_y.neg ? (~{1'b0, i_mag_y} + 1'b1) : {1'b0, i_mag_y};
    assign w_sx    = {2'b00, i_pixel_x} - w_off_x;
    assign w_sy    = {2'b00, i_pixel_y} - w_off_y;

    // top two bits clear: non-negative and below the coordinate span
    assign w_ok_x = (w_sx[C+1:C] == 2'b00) && (CMPW'(w_sx[C-1:0]) < CMPW'(i_image_width));
    assign w_ok_y = (w_sy[C+1:C] == 2'b00) && (CMPW'(w_sy[C-1:0]) < CMPW'(i_image_height));
    assign w_ok   = w_ok_x & w_ok_y;

    logic         r_o_v, r_skid_v, n_skid_v;
    logic [C-1:0] r_o_sx, r_o_sy, r_sk_sx, r_sk_sy;
    logic         r_o_ok, r_sk_ok;

    // pipeline moves whenever the skid register is free
    assign o_adv = !r_skid_v;

    always_comb begin
        n_skid_v = r_skid_v;
        if (!r_skid_v) begin
            n_skid_v = r_o_v & !i_m_tready;
        end else if (i_m_tready) begin
            n_skid_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v    <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_skid_v <= n_skid_v;
            if (o_adv) begin
                r_o_v <= w_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_o_sx  <= w_ok ? w_sx[C-1:0] : '0;
            r_o_sy  <= w_ok ? w_sy[C-1:0] : '0;
            r_o_ok  <= w_ok;
            r_sk_sx <= r_o_sx;
            r_sk_sy <= r_o_sy;
            r_sk_ok <= r_o_ok;
        end
    end

    assign o_valid    = r_skid_v | r_o_v;
    assign o_source_x = r_skid_v ? r_sk_sx : r_o_sx;
    assign o_source_y = r_skid_v ? r_sk_sy : r_o_sy;
    assign o_in_range = r_skid_v ? r_sk_ok : r_o_ok;

endmodule

[rtl/core/rdr_sva.sv]
// ---------------------------------------------------------------------------
// rdr_sva
// Port-level checks for the remap unit, bound onto the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rdr_sva #(
    parameter int COORD_BITS = rdr_pkg::COORD_BITS_DEF
) (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    o_s_axis_tready,
    input logic                                    o_m_axis_tvalid,
    input logic                                    i_m_axis_tready,
    input logic [rdr_pkg::tdata_w(COORD_BITS)-1:0] o_m_axis_tdata,
    input logic [0:0]                              o_m_axis_tuser
);

    // a pending beat stays up until taken
`ASSERT_NXT(a_valid_held, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result beat dropped while stalled")

    // and does not change under stall
`ASSERT_NXT(a_data_held, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result beat changed while stalled")

    // out-of-image results carry a zero coordinate pair
`ASSERT_IMP(a_zero_when_out, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == 1'b0), o_m_axis_tdata == '0, "nonzero source with in_range low")

    // input side only stalls when a parked result is on the output
`ASSERT_IMP(a_stall_backed, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid, "input stalled with no result pending")

    // draining the parked result frees the input side next cycle
`ASSERT_NXT(a_stall_clears, i_clk, i_rst_n, !o_s_axis_tready && i_m_axis_tready, o_s_axis_tready, "input still stalled after skid drained")

endmodule

bind radial_distortion_remap_unit rdr_sva #(
    .COORD_BITS (COORD_BITS)
) u_rdr_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[dv/rdr_remap_checker.sv]
// ---------------------------------------------------------------------------
// rdr_remap_checker
// Watches the pixel, source and register ports of the remap unit. Predicts
// each source beat with exact 128-bit arithmetic and compares it in order.
// ---------------------------------------------------------------------------
module rdr_remap_checker #(
    parameter int COORD_BITS = rdr_pkg::COORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    input  logic                                     i_s_tready,
    // tdata: pixel_x, pixel_y, zero pad
    input  logic [rdr_pkg::tdata_w(COORD_BITS)-1:0]  i_s_tdata,
    input  logic                                     i_m_tvalid,
    input  logic                                     i_m_tready,
    // tdata: source_x, source_y, zero pad
    input  logic [rdr_pkg::tdata_w(COORD_BITS)-1:0]  i_m_tdata,
    // tuser: in_range
    input  logic [0:0]                               i_m_tuser,
    input  logic                                     i_cfg_we,
    input  logic [rdr_pkg::CFG_ADDR_W-1:0]           i_cfg_addr,
    input  logic [rdr_pkg::CFG_DATA_W-1:0]           i_cfg_wdata,
    output int                                       o_fail_count,
    output int                                       o_pending_count
);

    localparam longint SPAN = longint'(1) << COORD_BITS;
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic [COORD_BITS-1:0] src_x;
        logic [COORD_BITS-1:0] src_y;
        logic                  in_range;
    } t_source_beat;

    // shadow copy of the register file
    logic [rdr_pkg::CENTER_W-1:0]      center_x, center_y;
    logic signed [rdr_pkg::COEF_W-1:0] k1, k2;
    logic [rdr_pkg::SIZE_W-1:0]        img_w, img_h;

    t_source_beat expected_sources[$];
    int           mismatches = 0;
    int           result_idx = 0;

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    // trunc(d * gain / 2^64), magnitude clipped to the coordinate span
    function automatic longint radial_offset(input longint d, input logic signed [127:0] gain);
        logic signed [127:0] prod;
        logic [127:0]        mag;
        logic [63:0]         whole;
        longint              lim;
        prod  = gain * d;
        mag   = prod[127] ? -prod : prod;
        whole = mag[127:64];
        lim   = (whole > 64'(SPAN)) ? SPAN : longint'(whole);
        return prod[127] ? -lim : lim;
    endfunction

    function automatic t_source_beat predict_source(input logic [COORD_BITS-1:0] px,
                                                    input logic [COORD_BITS-1:0] py);
        longint              x, y, dx, dy, s, sx, sy, w, h;
        logic signed [127:0] k1w, k2w, gain;
        t_source_beat        r;
        x    = longint'(px);
        y    = longint'(py);
        dx   = x - (longint'(center_x) & (SPAN - 1));
        dy   = y - (longint'(center_y) & (SPAN - 1));
        s    = dx * dx + dy * dy;
        k1w  = k1;
        k2w  = k2;
        // both terms in units of 2^-64
        gain = (k1w <<< rdr_pkg::K1_SHIFT) * s + k2w * s * s;
        sx   = x - radial_offset(dx, gain);
        sy   = y - radial_offset(dy, gain);
        // oversized image acts as the full span
        w    = (longint'(img_w) > SPAN) ? SPAN : longint'(img_w);
        h    = (longint'(img_h) > SPAN) ? SPAN : longint'(img_h);
        r.in_range = (sx >= 0) && (sy >= 0) && (sx < w) && (sy < h);
        r.src_x    = r.in_range ? sx[COORD_BITS-1:0] : '0;
        r.src_y    = r.in_range ? sy[COORD_BITS-1:0] : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_source_beat seen, want;
        if (!i_rst_n) begin
            center_x = rdr_pkg::CENTER_RESET;
            center_y = rdr_pkg::CENTER_RESET;
            k1       = rdr_pkg::K1_RESET;
            k2       = rdr_pkg::K2_RESET;
            img_w    = rdr_pkg::SIZE_RESET;
            img_h    = rdr_pkg::SIZE_RESET;
            expected_sources.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rdr_pkg::REG_CENTER_X:     center_x = i_cfg_wdata[rdr_pkg::CENTER_W-1:0];
                    rdr_pkg::REG_CENTER_Y:     center_y = i_cfg_wdata[rdr_pkg::CENTER_W-1:0];
                    rdr_pkg::REG_K1_COEFF:     k1       = i_cfg_wdata[rdr_pkg::COEF_W-1:0];
                    rdr_pkg::REG_K2_COEFF:     k2       = i_cfg_wdata[rdr_pkg::COEF_W-1:0];
                    rdr_pkg::REG_IMAGE_WIDTH:  img_w    = i_cfg_wdata[rdr_pkg::SIZE_W-1:0];
                    rdr_pkg::REG_IMAGE_HEIGHT: img_h    = i_cfg_wdata[rdr_pkg::SIZE_W-1:0];
                    default: ;  // unmapped index, dropped
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_sources.insert(expected_sources.size(), predict_source(
                    i_s_tdata[COORD_BITS-1:0], i_s_tdata[2*COORD_BITS-1:COORD_BITS]));
            if (i_m_tvalid && i_m_tready) begin
                seen.src_x    = i_m_tdata[COORD_BITS-1:0];
                seen.src_y    = i_m_tdata[2*COORD_BITS-1:COORD_BITS];
                seen.in_range = i_m_tuser[0];
                if (expected_sources.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("source beat %0d with nothing outstanding: x=%0d y=%0d in=%0b",
                                 result_idx, seen.src_x, seen.src_y, seen.in_range);
                end else begin
                    want = expected_sources.pop_front();
                    if (seen.src_x !== want.src_x || seen.src_y !== want.src_y ||
                        seen.in_range !== want.in_range) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("source beat %0d: exp x=%0d y=%0d in=%0b, got x=%0d y=%0d in=%0b",
                                     result_idx, want.src_x, want.src_y, want.in_range,
                                     seen.src_x, seen.src_y, seen.in_range);
                    end
                end
                result_idx++;
            end
        end
        o_pending_count <= expected_sources.size();
        o_fail_count    <= mismatches;
    end

endmodule

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the radial distortion remap unit: directed corner beats under
// hand-picked register settings, then random settings with random pixels.
// Checking is done by rdr_remap_checker; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int C  = rdr_pkg::COORD_BITS_DEF;
    localparam int DW = rdr_pkg::tdata_w(C);

    // indexes past the end of the register map; writes there must be dropped
    localparam logic [rdr_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [rdr_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int IDLE_PCT     = 26;    // chance per cycle of a gap or stall
    localparam int DRAIN_CYCLES = 16;    // pipeline is 9 deep, plus margin
    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat or register write before giving up
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_BEATS  = 75;

    localparam logic [C-1:0] MAX_COORD = '1;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [DW-1:0]                  i_s_axis_tdata = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [DW-1:0]                  o_m_axis_tdata;
    logic [0:0]                     o_m_axis_tuser;
    logic                           i_cfg_we = 1'b0;
    logic [rdr_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [rdr_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int failures;
    int results_owed;

    // center in use, so random pixels can cluster around it
    int cur_cx = 0;
    int cur_cy = 0;

    // while set, neither side inserts gaps or stalls
    logic steady_run = 1'b0;

    radial_distortion_remap_unit #(.COORD_BITS(C)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    rdr_remap_checker #(.COORD_BITS(C)) remap_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_axis_tvalid),
        .i_s_tready      (o_s_axis_tready),
        .i_s_tdata       (i_s_axis_tdata),
        .i_m_tvalid      (o_m_axis_tvalid),
        .i_m_tready      (i_m_axis_tready),
        .i_m_tdata       (o_m_axis_tdata),
        .i_m_tuser       (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (failures),
        .o_pending_count (results_owed)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit take_gap();
        return !steady_run && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Sink side: random backpressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_m_axis_tready <= !take_gap();
    end

    // Watchdog: any beat on either stream or a register write counts as progress.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One register write per cycle; the caller drops the enable when done.
    task automatic write_reg(input logic [rdr_pkg::CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input int cx, input int cy, input logic [31:0] k1,
                                 input logic [31:0] k2, input int w, input int h);
        write_reg(rdr_pkg::REG_CENTER_X, cx);
        write_reg(rdr_pkg::REG_CENTER_Y, cy);
        write_reg(rdr_pkg::REG_K1_COEFF, k1);
        write_reg(rdr_pkg::REG_K2_COEFF, k2);
        write_reg(rdr_pkg::REG_IMAGE_WIDTH, w);
        write_reg(rdr_pkg::REG_IMAGE_HEIGHT, h);
        i_cfg_we <= 1'b0;
        cur_cx = cx;
        cur_cy = cy;
        @(posedge i_clk);
    endtask

    // Offer one pixel beat; valid only drops when a gap is actually taken,
    // so back-to-back beats keep valid high with a single NBA per step.
    task automatic send_pixel(input int px, input int py);
        if (take_gap()) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (take_gap());
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {py[C-1:0], px[C-1:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stop offering beats and let every outstanding source beat come back.
    // The first edge makes sure the checker has seen the last accepted beat.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Coefficients: moderate in a third of draws so offsets stay inside the image,
    // with the signed extremes, zero and full-range values mixed in.
    function automatic logic [31:0] draw_coeff(input int span_bits);
        int v;
        case ($urandom_range(5))
            0: v = 0;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            3: v = $urandom();
            default: v = int'($urandom_range(0, 2 << span_bits)) - (1 << span_bits);
        endcase
        return v;
    endfunction

    // Image size: zero, one, full, oversized or anything in between.
    function automatic int draw_size();
        case ($urandom_range(7))
            0: return 0;
            1: return 1;
            2: return $urandom_range(4097, 8191);
            3: return 4096;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic int draw_center();
        case ($urandom_range(3))
            0: return 0;
            1: return MAX_COORD;
            default: return $urandom_range(0, MAX_COORD);
        endcase
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    task automatic random_settings();
        load_settings(draw_center(), draw_center(), draw_coeff(22), draw_coeff(10),
                      draw_size(), draw_size());
    endtask

    // Half the pixels anywhere in the frame, the rest close to the center,
    // where the gain is small and sources tend to land in range.
    task automatic random_pixels(input int count);
        int px, py;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1)) begin
                px = $urandom_range(0, MAX_COORD);
                py = $urandom_range(0, MAX_COORD);
            end else begin
                px = clamp_coord(cur_cx + int'($urandom_range(0, 128)) - 64);
                py = clamp_coord(cur_cy + int'($urandom_range(0, 128)) - 64);
            end
            send_pixel(px, py);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: center at the origin, strong k2 saturates far corners.
        send_pixel(0, 0);
        send_pixel(MAX_COORD, MAX_COORD);
        send_pixel(0, MAX_COORD);
        send_pixel(MAX_COORD, 0);
        send_pixel(1, 1);
        send_pixel(2048, 2048);
        drain();

        // Unmapped indexes first (must be ignored), then identity map with an
        // oversized image, which should clip to the full coordinate span.
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0000);
        load_settings(MAX_COORD, MAX_COORD, 0, 0, 8191, 8191);
        send_pixel(MAX_COORD, MAX_COORD);
        send_pixel(0, 0);
        send_pixel(MAX_COORD, 0);
        send_pixel(0, MAX_COORD);
        drain();

        // Zero-sized image: nothing is ever in range.
        load_settings(0, 0, rdr_pkg::K1_RESET, rdr_pkg::K2_RESET, 0, 0);
        send_pixel(0, 0);
        send_pixel(5, 7);
        drain();

        // One-pixel image, identity map: only the origin is in range.
        load_settings(0, 0, 0, 0, 1, 1);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(0, 1);
        drain();

        // Coefficient extremes of opposite sign around a mid-frame center.
        load_settings(2048, 2048, 32'h7FFF_FFFF, 32'h8000_0000, 4096, 4096);
        send_pixel(2049, 2048);
        send_pixel(2048, 2049);
        send_pixel(2048, 2048);
        send_pixel(2047, 2047);
        send_pixel(0, 0);
        send_pixel(MAX_COORD, MAX_COORD);
        drain();

        // Random phases; one of them runs with no gaps or stalls at all.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_settings();
            steady_run <= (ph == 3);
            random_pixels(PHASE_BEATS);
            drain();
        end

        if (failures == 0 && results_owed == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
